FILE: rtl/hotp_pkg.sv
// package for the hotp code validator: payload types, constants, state enum
package hotp_pkg;

    typedef struct packed {
        logic [63:0] moving_factor;
        logic [19:0] given_code;
    } hotp_in_t;

    typedef struct packed {
        logic [19:0] computed_code;
        logic        code_matches;
    } hotp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_TRUNC,
        ST_MOD,
        ST_DONE
    } hotp_state_t;

    localparam logic [0:0] CFG_KEY_HIGH = 1'd0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'd1;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    localparam logic [31:0] MOD_CODE = 32'd1000000;

    // floor(2^32 / 15625); 1000000 = 64 * 15625
    localparam logic [18:0] MOD_RECIP = 19'd274877;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

FILE: rtl/hotp_code_validator.sv
// hotp code validator: hmac-sha1 of the moving factor, truncation and code compare
// sequence from acceptance to out_valid: four compressions, each a load, the rounds and an add,
//   then a truncate step and a reciprocal multiply, back-multiply and correction for mod 1000000
// one word at a time: in_stall stays high until the result leaves
// one sha-1 round unit is shared by all rounds; the schedule is a 16-word shift register
// reset clears the key registers, state and valid; payload registers are not reset
module hotp_code_validator
    import hotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  hotp_in_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output hotp_out_t   out_word
);

    // configuration registers
    logic [15:0] key_high_reg;
    logic [63:0] key_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data[15:0];
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    hotp_state_t  state_reg, state_next;
    logic [1:0]   blk_reg, blk_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [1:0]   div_reg, div_next;
    logic [511:0] w_reg, w_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [159:0] h_reg, h_next;
    logic [159:0] inner_reg, inner_next;
    logic [63:0]  factor_reg, factor_next;
    logic [19:0]  given_reg, given_next;
    logic [31:0]  bin_reg, bin_next;
    logic [31:0]  rem_reg, rem_next;
    logic [11:0]  q_reg, q_next;
    hotp_out_t    out_reg, out_next;

    // padded message block for the current compression
    logic [79:0]  key80;
    logic [511:0] key_blk;
    logic [511:0] msg_blk;

    always_comb
    begin
        key80   = {key_high_reg, key_low_reg};
        key_blk = {key80, 432'd0};
        case (blk_reg)
            2'd0: msg_blk = key_blk ^ {64{IPAD}};
            2'd1: msg_blk = {factor_reg, 8'h80, 424'd0, 16'h0240};
            2'd2: msg_blk = key_blk ^ {64{OPAD}};
            default: msg_blk = {inner_reg, 8'h80, 328'd0, 16'h02A0};
        endcase
    end

    // shared round unit
    logic [31:0] f_val, k_val, t_val, w_cur, w_new;
    logic [31:0] sum_a, sum_b, sum_c, sum_d, sum_e;
    logic [7:0]  mac_byte [20];
    logic [3:0]  off;
    logic [31:0] ext;
    logic [43:0] prod;
    logic [31:0] rem_fix;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = 32'h8F1BBCDC;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'hCA62C1D6;
        end
        w_cur = w_reg[511:480];
        w_new = rotl(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480], 1);
        t_val = rotl(a_reg, 5) + f_val + e_reg + k_val + w_cur;
        sum_a = h_reg[159:128] + a_reg;
        sum_b = h_reg[127:96] + b_reg;
        sum_c = h_reg[95:64] + c_reg;
        sum_d = h_reg[63:32] + d_reg;
        sum_e = h_reg[31:0] + e_reg;
        for (int i = 0; i < 20; i++)
        begin
            mac_byte[i] = h_reg[159 - 8*i -: 8];
        end
        off = mac_byte[19][3:0];
        ext = {1'b0, mac_byte[off][6:0], mac_byte[5'(off) + 5'd1],
               mac_byte[5'(off) + 5'd2], mac_byte[5'(off) + 5'd3]};
        // quotient estimate (bin >> 6) / 15625, low by at most one
        prod = {19'd0, bin_reg[30:6]} * {25'd0, MOD_RECIP};
        // final correction of the remainder
        rem_fix = (rem_reg >= MOD_CODE) ? (rem_reg - MOD_CODE) : rem_reg;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        rnd_next    = rnd_reg;
        div_next    = div_reg;
        w_next      = w_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        h_next      = h_reg;
        inner_next  = inner_reg;
        factor_next = factor_reg;
        given_next  = given_reg;
        bin_next    = bin_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        out_next    = out_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    factor_next = in_word.moving_factor;
                    given_next  = in_word.given_code;
                    blk_next    = 2'd0;
                    h_next      = {H0, H1, H2, H3, H4};
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                w_next = msg_blk;
                a_next = h_reg[159:128];
                b_next = h_reg[127:96];
                c_next = h_reg[95:64];
                d_next = h_reg[63:32];
                e_next = h_reg[31:0];
                rnd_next   = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                e_next = d_reg;
                d_next = c_reg;
                c_next = rotl(b_reg, 30);
                b_next = a_reg;
                a_next = t_val;
                w_next = {w_reg[479:0], w_new};
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                h_next = {sum_a, sum_b, sum_c, sum_d, sum_e};
                blk_next = blk_reg + 2'd1;
                state_next = ST_LOAD;
                if (blk_reg == 2'd1)
                begin
                    inner_next = {sum_a, sum_b, sum_c, sum_d, sum_e};
                    h_next     = {H0, H1, H2, H3, H4};
                end
                else if (blk_reg == 2'd3)
                begin
                    state_next = ST_TRUNC;
                end
            end
            ST_TRUNC:
            begin
                bin_next   = ext;
                rem_next   = '0;
                div_next   = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                // reciprocal multiply, back-multiply and subtract, then one correction
                if (div_reg == 2'd0)
                begin
                    q_next   = prod[43:32];
                    div_next = 2'd1;
                end
                else if (div_reg == 2'd1)
                begin
                    rem_next = bin_reg - ({20'd0, q_reg} * MOD_CODE);
                    div_next = 2'd2;
                end
                else
                begin
                    out_next.computed_code = rem_fix[19:0];
                    out_next.code_matches  = (given_reg == rem_fix[19:0]);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            blk_reg   <= '0;
            rnd_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg   <= blk_next;
            rnd_reg   <= rnd_next;
            div_reg   <= div_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        h_reg      <= h_next;
        inner_reg  <= inner_next;
        factor_reg <= factor_next;
        given_reg  <= given_next;
        bin_reg    <= bin_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        out_reg    <= out_next;
    end

    assign out_word = out_reg;

endmodule

FILE: tb/sv/tb_hotp_code_validator.sv
// testbench for the hotp code validator: directed table plus random words checked by a predictor
`timescale 1ns / 1ps

module tb_hotp_code_validator
    import hotp_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    hotp_in_t    in_word;
    logic        out_valid;
    logic        out_stall;
    hotp_out_t   out_word;

    hotp_code_validator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    // predictor copy of the key registers
    logic [15:0] key_hi_m;
    logic [63:0] key_lo_m;

    hotp_out_t   code_queue[$];
    int          fail_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    typedef struct {
        logic [63:0] factor;
        logic [19:0] code;
        logic        known;
        logic [19:0] exp_code;
        logic        exp_match;
    } vec_row_t;

    // one sha-1 compression over a 512-bit block
    function automatic logic [159:0] sha1_compress(input logic [159:0] hin,
                                                   input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
            w[t] = blk[511 - 32 * t -: 32];
        for (int t = 16; t < 80; t++)
        begin
            tmp = w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16];
            w[t] = {tmp[30:0], tmp[31]};
        end
        {a, b, c, d, e} = hin;
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
                hin[63:32] + d, hin[31:0] + e};
    endfunction

    // hmac-sha1 of the factor, dynamic truncation and compare
    function automatic hotp_out_t predict_code(input logic [63:0] factor,
                                               input logic [19:0] given);
        logic [511:0] padded_key;
        logic [511:0] blk;
        logic [159:0] init_h;
        logic [159:0] inner_h;
        logic [159:0] mac_h;
        logic [3:0]   off;
        logic [31:0]  bin;
        logic [31:0]  code;
        hotp_out_t    r;
        init_h = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
        padded_key = {key_hi_m, key_lo_m, 432'd0};
        // inner hash, 576 bits total
        inner_h = sha1_compress(init_h, padded_key ^ {64{IPAD}});
        blk = {factor, 8'h80, 424'd0, 16'h0240};
        inner_h = sha1_compress(inner_h, blk);
        // outer hash, 672 bits total
        mac_h = sha1_compress(init_h, padded_key ^ {64{OPAD}});
        blk = {inner_h, 8'h80, 328'd0, 16'h02A0};
        mac_h = sha1_compress(mac_h, blk);
        off = mac_h[3:0];
        bin = mac_h[159 - 8 * off -: 32];
        bin[31] = 1'b0;
        code = bin % MOD_CODE;
        r.computed_code = code[19:0];
        r.code_matches = (given == code[19:0]);
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall and result check
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (code_queue.size() == 0)
                begin
                    $error("unexpected word: computed_code %0d", out_word.computed_code);
                    fail_count++;
                end
                else
                begin
                    if (out_word.computed_code !== code_queue[0].computed_code)
                    begin
                        $error("computed_code: expected %0d, got %0d",
                               code_queue[0].computed_code, out_word.computed_code);
                        fail_count++;
                    end
                    if (out_word.code_matches !== code_queue[0].code_matches)
                    begin
                        $error("code_matches: expected %0d, got %0d",
                               code_queue[0].code_matches, out_word.code_matches);
                        fail_count++;
                    end
                    void'(code_queue.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb_hotp_code_validator: errors");
            $finish;
        end
    end

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_HIGH)
            key_hi_m = val[15:0];
        else
            key_lo_m = val;
        @(posedge clk);
    endtask

    // present one word, wait for acceptance
    task automatic send_code(input logic [63:0] factor, input logic [19:0] given);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_word.moving_factor <= factor;
        in_word.given_code <= given;
        code_queue.push_back(predict_code(factor, given));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        while (code_queue.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random factor: small counters, time steps or full 64-bit values
    function automatic logic [63:0] pick_factor();
        case ($urandom_range(3))
            0: return 64'($urandom_range(1000));
            1: return 64'($urandom_range(60000000));
            default: return rand64();
        endcase
    endfunction

    task automatic run_random(input int n);
        hotp_out_t   hint;
        logic [63:0] f;
        logic [19:0] g;
        for (int i = 0; i < n; i++)
        begin
            f = pick_factor();
            case ($urandom_range(3))
                0:
                begin
                    // well-formed code: the right answer
                    hint = predict_code(f, 20'd0);
                    g = hint.computed_code;
                end
                1: g = 20'($urandom_range(999999));
                2: g = 20'($urandom_range(20'hFFFFF, 1000000));
                default: g = 20'($urandom());
            endcase
            send_code(f, g);
        end
    endtask

    vec_row_t   vec_table[$];
    hotp_out_t  hint;
    vec_row_t   row;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_HIGH;
        cfg_data = 64'd0;
        in_valid = 1'b0;
        in_word = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 25;
        recv_idle_pct = 87;
        key_hi_m = 16'd0;
        key_lo_m = 64'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset key; out of range codes never match
        vec_table.push_back('{64'd0, 20'd0, 1'b0, 20'd0, 1'b0});
        vec_table.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 20'd999999, 1'b0, 20'd0, 1'b0});
        vec_table.push_back('{64'd1, 20'd1000000, 1'b1, 20'd0, 1'b0});
        vec_table.push_back('{64'd1, 20'hFFFFF, 1'b1, 20'd0, 1'b0});
        vec_table.push_back('{64'h8000_0000_0000_0000, 20'h55555, 1'b0, 20'd0, 1'b0});
        vec_table.push_back('{64'h5555_5555_5555_5555, 20'hAAAAA, 1'b0, 20'd0, 1'b0});
        vec_table.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 20'd0, 1'b0, 20'd0, 1'b0});
        foreach (vec_table[i])
        begin
            row = vec_table[i];
            if (row.known)
            begin
                // out of range code: match must be clear whatever the hash gives
                hint = predict_code(row.factor, row.code);
                if (hint.code_matches !== row.exp_match)
                begin
                    $error("code_matches: expected %0d, got %0d",
                           row.exp_match, hint.code_matches);
                    fail_count++;
                end
            end
            send_code(row.factor, row.code);
        end
        // a matching code at each extreme factor
        hint = predict_code(64'd0, 20'd0);
        send_code(64'd0, hint.computed_code);
        hint = predict_code(64'hFFFF_FFFF_FFFF_FFFF, 20'd0);
        send_code(64'hFFFF_FFFF_FFFF_FFFF, hint.computed_code);
        drain();

        // all-ones key, upper data bits of key_high must be masked
        write_key(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        key_hi_m = 16'hFFFF;
        for (int i = 0; i < 8; i++)
        begin
            hint = predict_code(64'(i), 20'd0);
            send_code(64'(i), (i[0]) ? hint.computed_code : 20'($urandom()));
        end
        run_random(300);
        drain();

        // idling swapped, random key
        send_idle_pct = 87;
        recv_idle_pct = 25;
        write_key(CFG_KEY_HIGH, rand64());
        key_hi_m = cfg_data[15:0];
        write_key(CFG_KEY_LOW, rand64());
        run_random(450);
        drain();

        // no idling, alternating key patterns, then a random key
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_key(CFG_KEY_HIGH, 64'h5555);
        write_key(CFG_KEY_LOW, 64'hAAAA_AAAA_AAAA_AAAA);
        run_random(450);
        drain();
        write_key(CFG_KEY_HIGH, 64'hAAAA);
        write_key(CFG_KEY_LOW, 64'h5555_5555_5555_5555);
        run_random(300);
        drain();
        write_key(CFG_KEY_HIGH, rand64());
        key_hi_m = cfg_data[15:0];
        write_key(CFG_KEY_LOW, rand64());
        run_random(300);
        drain();

        if (fail_count == 0)
            $display("tb_hotp_code_validator: clean");
        else
            $display("tb_hotp_code_validator: errors");
        $finish;
    end

endmodule
